FILE: rtl/dts_pkg.sv
// ----------------------------------------------------------------------------
// dts_pkg
// Types and codes shared by the deadline timer scheduler: command and result
// codes, the input and result beat layouts and the slot table entry.
// ----------------------------------------------------------------------------
`default_nettype none

package dts_pkg;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_ARM    = 2'd1,
    CMD_DETACH = 2'd2
  } dts_cmd_e;

  typedef enum logic [1:0] {
    KIND_ARM    = 2'd0,
    KIND_DETACH = 2'd1,
    KIND_FIRE   = 2'd2,
    KIND_SUM    = 2'd3
  } dts_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_FIX,
    ST_MIN,
    ST_SUM
  } dts_state_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [30:0] ticks;
    logic        repeat_req;
    logic [15:0] tag;
    logic [2:0]  slot_sel;
  } dts_in_t;

  typedef struct packed {
    dts_kind_e   kind;
    logic        ok;
    logic [2:0]  slot;
    logic [15:0] fire_tag;
    logic [15:0] next_delta;
    logic        last;
  } dts_out_t;

  typedef struct packed {
    logic [31:0] deadline;
    logic [30:0] interval;
    logic [15:0] tag;
  } dts_entry_t;

  // minimum tracker start value, also the "no slot busy" marker
  localparam logic [31:0] NO_BEST = 32'hFFFF_FFFF;

endpackage

`default_nettype wire

FILE: rtl/deadline_timer_scheduler.sv
// ----------------------------------------------------------------------------
// deadline_timer_scheduler
// Timer slot table with 32-bit deadlines held in a synchronous RAM with separate read and write ports.
// Arm and detach are handled on acceptance; a tick sweeps the table slot by slot.
// Arm/detach: reply is in the output register in the cycle after acceptance.
// Tick: steps through one read, then evaluate, write back and minimum per slot
//   through the table, then the summary; a fire or summary beat waits while
//   out_stall_i holds the output register, and the next beat is taken once
//   the summary is loaded and the scheduler is back in idle.
// Reset clears time and busy flags; table contents stay undefined until armed.
// ----------------------------------------------------------------------------
`default_nettype none

module deadline_timer_scheduler import dts_pkg::*; #(
  parameter int NUM_SLOTS  = 8,
  parameter int MAX_WINDOW = 65534
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire dts_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output dts_out_t      out_data_o
);

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(NUM_SLOTS - 1);
  localparam logic [31:0] WINDOW = 32'(MAX_WINDOW);

  dts_state_e state_q, state_d;
  logic [31:0] now_q, now_d;
  logic [NUM_SLOTS-1:0] busy_q, busy_d;
  logic [SLOT_W-1:0] idx_q, idx_d;
  logic [31:0] best_q, best_d;

  logic fire_q, fire_d;
  logic rep_q, rep_d;
  logic live_q, live_d;
  logic [31:0] nd1_q, nd1_d;
  logic [31:0] alt_q, alt_d;
  logic [31:0] fin_q, fin_d;
  logic [15:0] tag_q, tag_d;

  // slot table
  dts_entry_t mem [NUM_SLOTS];
  dts_entry_t rd_q;
  logic rd_en;
  logic [SLOT_W-1:0] rd_addr;
  logic wr_en;
  logic [SLOT_W-1:0] wr_addr;
  dts_entry_t wr_data;

  // output register
  logic out_valid_q;
  dts_out_t out_q, out_d;
  logic out_load;
  logic out_free;
  logic in_acc;

  logic free_found;
  logic [SLOT_W-1:0] free_idx;
  logic sel_ok;
  logic [SLOT_W-1:0] sel_idx;
  logic sel_busy;

  logic [31:0] diff0;
  logic [31:0] diff1;
  logic [31:0] dist_raw;
  logic [31:0] dist_c;
  logic [31:0] sum_delta;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && out_free);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!busy_q[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  assign sel_ok   = ({29'd0, in_data_i.slot_sel} < 32'(NUM_SLOTS));
  assign sel_idx  = SLOT_W'(in_data_i.slot_sel);
  assign sel_busy = sel_ok ? busy_q[sel_idx] : 1'b0;

  assign diff0    = now_q - rd_q.deadline;
  assign diff1    = now_q - nd1_q;
  assign dist_raw = fin_q - now_q;
  assign dist_c   = ((dist_raw == '0) || dist_raw[31]) ? 32'd1 : dist_raw;
  assign sum_delta = (best_q == NO_BEST) ? 32'd0 :
                     (best_q > WINDOW)   ? WINDOW : best_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_data_i.cmd == CMD_TICK)) state_d = ST_READ;
      end
      ST_READ: state_d = ST_CALC;
      ST_CALC: state_d = ST_FIX;
      ST_FIX: begin
        if (!fire_q || out_free) state_d = ST_MIN;
      end
      ST_MIN: begin
        state_d = (idx_q == LAST_IDX) ? ST_SUM : ST_CALC;
      end
      ST_SUM: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    now_d    = now_q;
    busy_d   = busy_q;
    idx_d    = idx_q;
    best_d   = best_q;
    fire_d   = fire_q;
    rep_d    = rep_q;
    live_d   = live_q;
    nd1_d    = nd1_q;
    alt_d    = alt_q;
    fin_d    = fin_q;
    tag_d    = tag_q;
    rd_en    = 1'b0;
    rd_addr  = idx_q;
    wr_en    = 1'b0;
    wr_addr  = idx_q;
    wr_data  = rd_q;
    out_load = 1'b0;
    out_d    = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          priority case (in_data_i.cmd)
            CMD_TICK: begin
              now_d  = now_q + 32'd1;
              idx_d  = '0;
              best_d = NO_BEST;
            end
            CMD_ARM: begin
              out_load   = 1'b1;
              out_d.kind = KIND_ARM;
              out_d.last = 1'b1;
              if ((in_data_i.ticks != '0) && free_found) begin
                busy_d[free_idx] = 1'b1;
                wr_en            = 1'b1;
                wr_addr          = free_idx;
                wr_data.deadline = now_q + {1'b0, in_data_i.ticks};
                wr_data.interval = in_data_i.repeat_req ? in_data_i.ticks : '0;
                wr_data.tag      = in_data_i.tag;
                out_d.ok         = 1'b1;
                out_d.slot       = 3'(free_idx);
              end
            end
            CMD_DETACH: begin
              out_load   = 1'b1;
              out_d.kind = KIND_DETACH;
              out_d.slot = in_data_i.slot_sel;
              out_d.last = 1'b1;
              if (sel_busy) begin
                busy_d[sel_idx] = 1'b0;
                out_d.ok        = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        rd_en = 1'b1;
      end
      ST_CALC: begin
        fire_d = busy_q[idx_q] && !diff0[31];
        rep_d  = (rd_q.interval != '0);
        nd1_d  = rd_q.deadline + {1'b0, rd_q.interval};
        alt_d  = now_q + {1'b0, rd_q.interval};
        fin_d  = rd_q.deadline;
        tag_d  = rd_q.tag;
      end
      ST_FIX: begin
        if (!fire_q || out_free) begin
          live_d = busy_q[idx_q];
          if (fire_q) begin
            out_load       = 1'b1;
            out_d.kind     = KIND_FIRE;
            out_d.ok       = 1'b1;
            out_d.slot     = 3'(idx_q);
            out_d.fire_tag = tag_q;
            if (rep_q) begin
              // still overdue after one period: resync to now + interval
              fin_d            = diff1[31] ? nd1_q : alt_q;
              wr_en            = 1'b1;
              wr_data.deadline = diff1[31] ? nd1_q : alt_q;
            end else begin
              busy_d[idx_q] = 1'b0;
              live_d        = 1'b0;
            end
          end
        end
      end
      ST_MIN: begin
        if (live_q && (dist_c < best_q)) best_d = dist_c;
        if (idx_q != LAST_IDX) begin
          idx_d   = idx_q + 1'b1;
          rd_en   = 1'b1;
          rd_addr = idx_q + 1'b1;
        end
      end
      ST_SUM: begin
        if (out_free) begin
          out_load         = 1'b1;
          out_d.kind       = KIND_SUM;
          out_d.ok         = 1'b1;
          out_d.next_delta = sum_delta[15:0];
          out_d.last       = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      now_q       <= '0;
      busy_q      <= '0;
      idx_q       <= '0;
      best_q      <= NO_BEST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      now_q       <= now_d;
      busy_q      <= busy_d;
      idx_q       <= idx_d;
      best_q      <= best_d;
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    fire_q <= fire_d;
    rep_q  <= rep_d;
    live_q <= live_d;
    nd1_q  <= nd1_d;
    alt_q  <= alt_d;
    fin_q  <= fin_d;
    tag_q  <= tag_d;
    if (out_load) out_q <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) rd_q <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: tb/deadline_timer_scheduler_tb.sv
// ----------------------------------------------------------------------------
// deadline_timer_scheduler_tb
// Drives arm, detach, tick and unused-code beats into the timer slot table.
// Every accepted beat is run through a local slot table model, and each
// result beat is checked field by field against the oldest predicted reply.
// Both sides idle and stall at random, with calm stretches in between.
// ----------------------------------------------------------------------------
module deadline_timer_scheduler_tb;
  import dts_pkg::*;

  localparam int NUM_SLOTS      = 8;
  localparam int MAX_WINDOW     = 65534;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 3 * NUM_SLOTS + 18;
  localparam int RANDOM_ITEMS   = 480;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  dts_in_t  in_data_i   = '0;
  logic     out_stall_i = 1'b0;
  logic     in_stall_o;
  logic     out_valid_o;
  dts_out_t out_data_o;

  deadline_timer_scheduler #(
    .NUM_SLOTS (NUM_SLOTS),
    .MAX_WINDOW(MAX_WINDOW)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // slot table model
  logic [31:0] now_q;
  logic        slot_busy_q     [NUM_SLOTS];
  logic [31:0] slot_deadline_q [NUM_SLOTS];
  logic [30:0] slot_interval_q [NUM_SLOTS];
  logic [15:0] slot_tag_q      [NUM_SLOTS];

  dts_in_t  cmd_q[$];
  dts_out_t reply_q[$];

  int unsigned miss_cnt = 0;
  int unsigned idle_cycles;

  function automatic bit deadline_due(logic [31:0] deadline);
    logic [31:0] diff;
    diff = now_q - deadline;
    return !diff[31];
  endfunction

  task automatic timer_table_step(input dts_in_t beat);
    dts_out_t    r;
    int          free_idx;
    logic [31:0] soonest;
    logic [31:0] gap;
    free_idx = -1;
    r = '0;
    r.last = 1'b1;
    case (beat.cmd)
      CMD_ARM: begin
        r.kind = KIND_ARM;
        if (beat.ticks != '0) begin
          for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (!slot_busy_q[i]) free_idx = i;
          end
        end
        if (free_idx >= 0) begin
          slot_busy_q[free_idx]     = 1'b1;
          slot_interval_q[free_idx] = beat.repeat_req ? beat.ticks : '0;
          slot_deadline_q[free_idx] = now_q + {1'b0, beat.ticks};
          slot_tag_q[free_idx]      = beat.tag;
          r.ok   = 1'b1;
          r.slot = 3'(free_idx);
        end
        reply_q.push_back(r);
      end
      CMD_DETACH: begin
        r.kind = KIND_DETACH;
        r.slot = beat.slot_sel;
        if (int'(beat.slot_sel) < NUM_SLOTS && slot_busy_q[beat.slot_sel]) begin
          slot_busy_q[beat.slot_sel] = 1'b0;
          r.ok = 1'b1;
        end
        reply_q.push_back(r);
      end
      CMD_TICK: begin
        now_q = now_q + 32'd1;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (slot_busy_q[i] && deadline_due(slot_deadline_q[i])) begin
            r = '0;
            r.kind     = KIND_FIRE;
            r.ok       = 1'b1;
            r.slot     = 3'(i);
            r.fire_tag = slot_tag_q[i];
            reply_q.push_back(r);
            if (slot_interval_q[i] != '0) begin
              slot_deadline_q[i] = slot_deadline_q[i] + {1'b0, slot_interval_q[i]};
              // still overdue: skip the missed periods
              if (deadline_due(slot_deadline_q[i]))
                slot_deadline_q[i] = now_q + {1'b0, slot_interval_q[i]};
            end else begin
              slot_busy_q[i] = 1'b0;
            end
          end
        end
        soonest = 32'hFFFF_FFFF;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (slot_busy_q[i]) begin
            gap = slot_deadline_q[i] - now_q;
            if (gap == '0 || gap[31]) gap = 32'd1;
            if (gap < soonest) soonest = gap;
          end
        end
        r = '0;
        r.kind = KIND_SUM;
        r.ok   = 1'b1;
        r.last = 1'b1;
        if (soonest == 32'hFFFF_FFFF) r.next_delta = '0;
        else if (soonest > 32'(MAX_WINDOW)) r.next_delta = 16'(MAX_WINDOW);
        else r.next_delta = soonest[15:0];
        reply_q.push_back(r);
      end
      default: ;  // unused command code, no reply
    endcase
  endtask

  function automatic string result_text(dts_out_t r);
    return $sformatf("kind=%0d ok=%0d slot=%0d tag=%04h delta=%0d last=%0d",
                     r.kind, r.ok, r.slot, r.fire_tag, r.next_delta, r.last);
  endfunction

  task automatic log_miss(input string msg);
    miss_cnt++;
    if (miss_cnt <= 10) $display("%s", msg);
  endtask

  function automatic dts_in_t make_beat(logic [1:0] cmd, logic [30:0] ticks,
                                        logic rep, logic [15:0] tag,
                                        logic [2:0] sel);
    dts_in_t b;
    b.cmd        = cmd;
    b.ticks      = ticks;
    b.repeat_req = rep;
    b.tag        = tag;
    b.slot_sel   = sel;
    return b;
  endfunction

  function automatic logic [30:0] pick_ticks();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return '0;
    if (roll == 1) return 31'h7FFF_FFFF;
    if (roll <= 4) return 31'($urandom);
    // around the summary clamp
    if (roll == 5) return 31'($urandom_range(65530, 65540));
    return 31'($urandom_range(1, 12));
  endfunction

  // input driver
  int unsigned in_gap;
  int unsigned in_beats;
  bit          in_calm;

  always @(posedge clk_i or negedge rst_ni) begin
    dts_in_t nxt_data;
    logic    nxt_valid;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      in_gap   = 0;
      in_beats = 0;
      in_calm  = 1'b0;
      now_q    = '0;
      for (int i = 0; i < NUM_SLOTS; i++) slot_busy_q[i] = 1'b0;
    end else begin
      nxt_valid = in_valid_i;
      nxt_data  = in_data_i;
      if (in_valid_i && !in_stall_o) begin
        timer_table_step(in_data_i);
        nxt_valid = 1'b0;
        in_gap = in_calm ? 0 : $urandom_range(0, 4);
        in_beats++;
        if (in_beats % 40 == 0) in_calm = ($urandom_range(0, 3) == 0);
      end
      if (!nxt_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (cmd_q.size() > 0) begin
          nxt_valid = 1'b1;
          nxt_data  = cmd_q.pop_front();
        end
      end
      in_valid_i <= nxt_valid;
      in_data_i  <= nxt_data;
    end
  end

  // result monitor
  int unsigned out_hold;
  int unsigned out_beats;
  bit          out_calm;

  always @(posedge clk_i or negedge rst_ni) begin
    dts_out_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      out_hold  = 0;
      out_beats = 0;
      out_calm  = 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (reply_q.size() == 0) begin
          log_miss({"unexpected result: ", result_text(out_data_o)});
        end else begin
          want = reply_q.pop_front();
          if (out_data_o.kind !== want.kind || out_data_o.ok !== want.ok ||
              out_data_o.slot !== want.slot || out_data_o.fire_tag !== want.fire_tag ||
              out_data_o.next_delta !== want.next_delta || out_data_o.last !== want.last)
            log_miss({"mismatch: expected ", result_text(want),
                      " got ", result_text(out_data_o)});
        end
        out_hold = out_calm ? 0 : $urandom_range(0, 4);
        out_beats++;
        if (out_beats % 40 == 0) out_calm = ($urandom_range(0, 3) == 0);
      end else if (out_hold > 0) begin
        out_hold--;
      end
      out_stall_i <= (out_hold != 0);
    end
  end

  // cycles with no beat on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    int unsigned counted;
    int unsigned roll;
    int unsigned burst;
    logic [30:0] step;

    // directed part
    cmd_q.push_back(make_beat(CMD_TICK, '0, 1'b0, '0, '0));   // empty table
    cmd_q.push_back(make_beat(CMD_DETACH, '0, 1'b0, '0, 3'd0)); // free slot
    cmd_q.push_back(make_beat(CMD_DETACH, 31'h7FFF_FFFF, 1'b1, 16'hFFFF, 3'd7));
    cmd_q.push_back(make_beat(CMD_ARM, '0, 1'b1, 16'hFFFF, 3'd7)); // zero ticks
    cmd_q.push_back(make_beat(CMD_ARM, 31'd1, 1'b0, 16'hFFFF, '0));
    cmd_q.push_back(make_beat(CMD_ARM, 31'h7FFF_FFFF, 1'b1, 16'h0000, 3'd7));
    cmd_q.push_back(make_beat(CMD_ARM, 31'd2, 1'b1, 16'hA5A5, '0));
    cmd_q.push_back(make_beat(2'd3, 31'h7FFF_FFFF, 1'b1, 16'hFFFF, 3'd7)); // ignored
    cmd_q.push_back(make_beat(CMD_TICK, '0, 1'b0, '0, '0));
    cmd_q.push_back(make_beat(CMD_TICK, 31'h7FFF_FFFF, 1'b1, 16'hFFFF, 3'd7));
    for (int i = 0; i < 6; i++)
      cmd_q.push_back(make_beat(CMD_ARM, 31'd3, 1'b0, 16'(16'h1111 * (i + 1)), 3'(i)));
    cmd_q.push_back(make_beat(CMD_ARM, 31'd5, 1'b1, 16'h5A5A, '0)); // table full
    cmd_q.push_back(make_beat(CMD_TICK, '0, 1'b0, '0, '0));
    cmd_q.push_back(make_beat(CMD_TICK, '0, 1'b0, '0, '0));
    cmd_q.push_back(make_beat(CMD_TICK, '0, 1'b0, '0, '0));       // six fires
    cmd_q.push_back(make_beat(CMD_DETACH, '0, 1'b0, '0, 3'd1));
    cmd_q.push_back(make_beat(CMD_DETACH, '0, 1'b0, '0, 3'd1));   // already free
    cmd_q.push_back(make_beat(CMD_ARM, 31'h4000_0000, 1'b0, 16'h8001, '0));
    cmd_q.push_back(make_beat(CMD_TICK, '0, 1'b0, '0, '0));

    // random part
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 9);
      if (roll <= 1) begin
        // clear the table now and then, arm a group on one interval, tick past it
        if ($urandom_range(0, 1) == 0) begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            cmd_q.push_back(make_beat(CMD_DETACH, 31'($urandom), 1'($urandom),
                                      16'($urandom), 3'(i)));
            counted++;
          end
        end
        burst = $urandom_range(2, NUM_SLOTS);
        step  = 31'($urandom_range(1, 6));
        for (int i = 0; i < int'(burst); i++) begin
          cmd_q.push_back(make_beat(CMD_ARM, step, 1'($urandom), 16'($urandom),
                                    3'($urandom)));
          counted++;
        end
        for (int i = 0; i < int'(step) + int'($urandom_range(0, 3)); i++) begin
          cmd_q.push_back(make_beat(CMD_TICK, 31'($urandom), 1'($urandom),
                                    16'($urandom), 3'($urandom)));
          counted++;
        end
      end else if (roll <= 5) begin
        cmd_q.push_back(make_beat(CMD_TICK, 31'($urandom), 1'($urandom),
                                  16'($urandom), 3'($urandom)));
        counted++;
      end else if (roll <= 7) begin
        cmd_q.push_back(make_beat(CMD_ARM, pick_ticks(), 1'($urandom),
                                  16'($urandom), 3'($urandom)));
        counted++;
      end else if (roll == 8) begin
        cmd_q.push_back(make_beat(CMD_DETACH, 31'($urandom), 1'($urandom),
                                  16'($urandom), 3'($urandom)));
        counted++;
      end else begin
        cmd_q.push_back(make_beat(2'd3, 31'($urandom), 1'($urandom),
                                  16'($urandom), 3'($urandom)));
        counted++;
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (miss_cnt == 0 && reply_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: deadline_timer_scheduler.f
rtl/dts_pkg.sv
rtl/deadline_timer_scheduler.sv
tb/deadline_timer_scheduler_tb.sv
